// File: hw/rtl/lrm_pkg.sv
package lrm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int NUM_POS     = MAX_PATTERN + 1;
    localparam int PREFIX_LVLS = $clog2(NUM_POS);
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_CARET   = 8'h5E;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_0,
        REG_WORD_1,
        REG_WORD_2,
        REG_WORD_3,
        REG_LENGTH
    } lrm_reg_idx_t;

    // Parsed pattern as seen by the match engine
    typedef struct packed {
        logic [MAX_PATTERN-1:0][7:0] ch;
        logic [MAX_PATTERN-1:0]      star;
        logic [MAX_PATTERN-1:0]      any;
        logic [MAX_PATTERN-1:0]      item_valid;
        logic [NUM_POS-1:0]          pos_mask;
        logic [NUM_POS-1:0]          final_sel;
        logic                        start_anchor;
        logic                        end_anchor;
        logic                        busy;
    } lrm_pat_t;

endpackage

// File: hw/rtl/lrm_parser.sv
module lrm_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output lrm_pkg::lrm_pat_t                    pat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ITEM
    } state_t;

    state_t                                      state_reg, state_next;
    logic [lrm_pkg::MAX_PATTERN-1:0][7:0]        pat_byte_reg;
    logic [lrm_pkg::LEN_W-1:0]                   len_reg;
    logic [lrm_pkg::LEN_W-1:0]                   pos_reg, pos_next;
    logic [lrm_pkg::LEN_W-1:0]                   eff_len_reg, eff_len_next;
    logic [lrm_pkg::LEN_W-1:0]                   count_reg, count_next;
    logic                                        start_reg, start_next;
    logic                                        end_reg, end_next;
    logic [lrm_pkg::MAX_PATTERN-1:0][7:0]        ch_reg;
    logic [lrm_pkg::MAX_PATTERN-1:0]             star_reg;
    logic [lrm_pkg::MAX_PATTERN-1:0]             any_reg;

    logic [lrm_pkg::LEN_W-1:0]                   limit;
    logic [lrm_pkg::LEN_W-1:0]                   pos_plus;
    logic [7:0]                                  cur_byte;
    logic [7:0]                                  nxt_byte;
    logic                                        item_we;
    logic                                        item_star;

    assign limit    = (len_reg > lrm_pkg::LEN_W'(lrm_pkg::MAX_PATTERN))
                    ? lrm_pkg::LEN_W'(lrm_pkg::MAX_PATTERN) : len_reg;
    assign pos_plus = pos_reg + 1'b1;
    assign cur_byte = pat_byte_reg[pos_reg[lrm_pkg::LEN_W-2:0]];
    assign nxt_byte = pat_byte_reg[pos_plus[lrm_pkg::LEN_W-2:0]];

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        eff_len_next = eff_len_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        end_next     = end_reg;
        item_we      = 1'b0;
        item_star    = 1'b0;
        if (cfg_valid)
        begin
            // any write restarts the parse from scratch
            state_next = S_SCAN;
            pos_next   = '0;
            count_next = '0;
            start_next = 1'b0;
            end_next   = 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                end
                S_SCAN:
                begin
                    // effective length stops at limit or first NUL byte
                    if (pos_reg == limit || cur_byte == lrm_pkg::CHAR_NUL)
                    begin
                        eff_len_next = pos_reg;
                        state_next   = S_ITEM;
                        if (pos_reg != '0 && pat_byte_reg[0] == lrm_pkg::CHAR_CARET)
                        begin
                            start_next = 1'b1;
                            pos_next   = lrm_pkg::LEN_W'(1);
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                    else
                    begin
                        pos_next = pos_plus;
                    end
                end
                S_ITEM:
                begin
                    if (pos_reg >= eff_len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (pos_plus < eff_len_reg && nxt_byte == lrm_pkg::CHAR_STAR)
                    begin
                        item_we    = 1'b1;
                        item_star  = 1'b1;
                        count_next = count_reg + 1'b1;
                        pos_next   = pos_reg + lrm_pkg::LEN_W'(2);
                    end
                    else if (cur_byte == lrm_pkg::CHAR_DOLLAR && pos_plus == eff_len_reg)
                    begin
                        end_next = 1'b1;
                        pos_next = pos_plus;
                    end
                    else
                    begin
                        item_we    = 1'b1;
                        count_next = count_reg + 1'b1;
                        pos_next   = pos_plus;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pat_byte_reg <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            eff_len_reg  <= '0;
            count_reg    <= '0;
            start_reg    <= 1'b0;
            end_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            eff_len_reg <= eff_len_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            end_reg     <= end_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    lrm_pkg::REG_WORD_0: pat_byte_reg[7:0]   <= cfg_data;
                    lrm_pkg::REG_WORD_1: pat_byte_reg[15:8]  <= cfg_data;
                    lrm_pkg::REG_WORD_2: pat_byte_reg[23:16] <= cfg_data;
                    lrm_pkg::REG_WORD_3: pat_byte_reg[31:24] <= cfg_data;
                    lrm_pkg::REG_LENGTH: len_reg <= cfg_data[lrm_pkg::LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // item table, only entries below count are ever read
    always_ff @(posedge clk)
    begin
        if (item_we)
        begin
            ch_reg[count_reg[lrm_pkg::LEN_W-2:0]]   <= cur_byte;
            star_reg[count_reg[lrm_pkg::LEN_W-2:0]] <= item_star;
            any_reg[count_reg[lrm_pkg::LEN_W-2:0]]  <= (cur_byte == lrm_pkg::CHAR_DOT);
        end
    end

    always_comb
    begin
        pat.ch           = ch_reg;
        pat.star         = star_reg;
        pat.any          = any_reg;
        pat.start_anchor = start_reg;
        pat.end_anchor   = end_reg;
        pat.busy         = (state_reg != S_IDLE);
        for (int k = 0; k < lrm_pkg::MAX_PATTERN; k++)
        begin
            pat.item_valid[k] = (lrm_pkg::LEN_W'(k) < count_reg);
        end
        for (int j = 0; j < lrm_pkg::NUM_POS; j++)
        begin
            pat.pos_mask[j]  = (lrm_pkg::LEN_W'(j) <= count_reg);
            pat.final_sel[j] = (lrm_pkg::LEN_W'(j) == count_reg);
        end
    end

endmodule

// File: hw/rtl/lrm_closure.sv
module lrm_closure (
    input  logic [lrm_pkg::NUM_POS-1:0]     set_in,
    input  logic [lrm_pkg::MAX_PATTERN-1:0] star_in,
    input  logic [lrm_pkg::NUM_POS-1:0]     mask_in,
    output logic [lrm_pkg::NUM_POS-1:0]     closed
);

    // c[j] = s[j] | (star[j-1] & c[j-1]), solved as a parallel prefix
    always_comb
    begin
        logic [lrm_pkg::NUM_POS-1:0] g;
        logic [lrm_pkg::NUM_POS-1:0] p;
        logic [lrm_pkg::NUM_POS-1:0] g_n;
        logic [lrm_pkg::NUM_POS-1:0] p_n;
        int                          d;
        g = set_in & mask_in;
        p = {star_in, 1'b0};
        for (int lvl = 0; lvl < lrm_pkg::PREFIX_LVLS; lvl++)
        begin
            d = 1 << lvl;
            for (int j = 0; j < lrm_pkg::NUM_POS; j++)
            begin
                if (j >= d)
                begin
                    g_n[j] = g[j] | (p[j] & g[j-d]);
                    p_n[j] = p[j] & p[j-d];
                end
                else
                begin
                    g_n[j] = g[j];
                    p_n[j] = p[j];
                end
            end
            g = g_n;
            p = p_n;
        end
        closed = g;
    end

endmodule

// File: hw/rtl/lrm_engine.sv
module lrm_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  lrm_pkg::lrm_pat_t   pat,
    input  logic                step_fire,
    input  logic [7:0]          step_byte,
    output logic                result_valid,
    output logic                result_bit
);

    logic [lrm_pkg::NUM_POS-1:0]     active_reg, active_next;
    logic                            stopped_reg, stopped_next;
    logic                            found_reg, found_next;

    logic [lrm_pkg::MAX_PATTERN-1:0] star_eff;
    logic [lrm_pkg::MAX_PATTERN-1:0] match;
    logic [lrm_pkg::MAX_PATTERN-1:0] hit;
    logic [lrm_pkg::NUM_POS-1:0]     cur;
    logic [lrm_pkg::NUM_POS-1:0]     adv;
    logic [lrm_pkg::NUM_POS-1:0]     new_active;
    logic [lrm_pkg::NUM_POS-1:0]     cur2;
    logic                            final_now;
    logic                            final_after;
    logic                            is_newline;

    assign star_eff = pat.star & pat.item_valid;

    lrm_closure u_close_cur (
        .set_in  (active_reg),
        .star_in (star_eff),
        .mask_in (pat.pos_mask),
        .closed  (cur)
    );

    always_comb
    begin
        for (int k = 0; k < lrm_pkg::MAX_PATTERN; k++)
        begin
            match[k] = pat.any[k] | (pat.ch[k] == step_byte);
        end
    end

    assign hit        = cur[lrm_pkg::MAX_PATTERN-1:0] & pat.item_valid & match;
    // starred items stay put, plain items move one position on
    assign adv        = {1'b0, hit & pat.star} | {hit & ~pat.star, 1'b0};
    assign new_active = adv | {{lrm_pkg::MAX_PATTERN{1'b0}}, ~pat.start_anchor};

    lrm_closure u_close_next (
        .set_in  (new_active),
        .star_in (star_eff),
        .mask_in (pat.pos_mask),
        .closed  (cur2)
    );

    assign final_now   = |(cur & pat.final_sel);
    assign final_after = |(cur2 & pat.final_sel);
    assign is_newline  = (step_byte == lrm_pkg::CHAR_NEWLINE);

    assign result_valid = step_fire & is_newline;
    assign result_bit   = found_reg | final_now;

    always_comb
    begin
        active_next  = active_reg;
        stopped_next = stopped_reg;
        found_next   = found_reg;
        if (step_fire)
        begin
            if (is_newline)
            begin
                active_next  = lrm_pkg::NUM_POS'(1);
                stopped_next = 1'b0;
                found_next   = 1'b0;
            end
            else if (!stopped_reg)
            begin
                if (step_byte == lrm_pkg::CHAR_NUL)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    active_next = new_active;
                    found_next  = found_reg | (~pat.end_anchor & (final_now | final_after));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= lrm_pkg::NUM_POS'(1);
            stopped_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            stopped_reg <= stopped_next;
            found_reg   <= found_next;
        end
    end

endmodule

// File: hw/rtl/line_regex_matcher.sv
// Channel  Direction  Handshake            Word
// -------  ---------  -------------------  -----------------------------------
// in       to block   in_valid/in_ready    text_byte: one text byte
// out      from block out_valid/out_ready  line_matched: verdict at each newline
// cfg      to block   cfg_valid/cfg_ready  cfg_index, cfg_data: register write
//
// One text byte per cycle sustained: a word sits in the input register and is
// folded into the position set in one pass (two prefix closures and a compare
// per pattern item) while the verdict goes to the output register.
// A newline waits in the input register while an earlier verdict is unread;
// other bytes keep flowing. cfg_ready is always high.
// Every register write restarts the pattern parse, one pattern byte a cycle;
// bytes are held in the input register until it ends.
// rst_n clears the pattern to empty length and the line state to line start.
module line_regex_matcher (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     text_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           line_matched,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0] cfg_data
);

    lrm_pkg::lrm_pat_t pat;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_bit_reg;
    logic       step_fire;
    logic       result_valid;
    logic       result_bit;

    lrm_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat       (pat)
    );

    // A held word steps when the pattern is settled and no register write
    // is offered; a newline also needs room in the output register.
    assign step_fire = in_valid_reg && !pat.busy && !cfg_valid
                    && (in_byte_reg != lrm_pkg::CHAR_NEWLINE || !out_valid_reg || out_ready);

    lrm_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .pat          (pat),
        .step_fire    (step_fire),
        .step_byte    (in_byte_reg),
        .result_valid (result_valid),
        .result_bit   (result_bit)
    );

    assign in_ready     = !in_valid_reg || step_fire;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign line_matched = out_bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (result_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= text_byte;
        end
        if (result_valid)
        begin
            out_bit_reg <= result_bit;
        end
    end

endmodule

// File: hw/rtl/lrm_checker.sv
module lrm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     text_byte,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           line_matched,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [lrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrm_pkg::CFG_DATA_W-1:0] cfg_data
);

    // a verdict holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_matched))
        else $error("verdict dropped or changed while stalled");

    // a text word offered and not taken stays offered, unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(text_byte))
        else $error("text word dropped or changed while stalled");

    // a register write offered and not taken stays offered, unchanged
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && !cfg_ready |=> cfg_valid && $stable(cfg_index) && $stable(cfg_data))
        else $error("register write dropped or changed while stalled");

    // a register write stalls the engine, so no verdict can start next cycle
    a_cfg_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !$rose(out_valid))
        else $error("verdict produced right after a register write");

    // a word held across a register write stays held as the pattern parse starts
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && !in_ready |=> !in_ready)
        else $error("input reopened during pattern parse");

endmodule

bind line_regex_matcher lrm_checker u_lrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .text_byte    (text_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_matched (line_matched),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
